// File: design/amqp_dfr_pkg.sv
// Shared types and constants for the AMQP 0-9-1 frame deframer.
// Used by amqp_dfr_core and amqp_frame_deframer_top; depends on nothing else.
package amqp_dfr_pkg;

    localparam int TDATA_W   = 104;
    localparam int HDR_LAST  = 6;   // index of the final header octet (7 octets)
    localparam int ID_LAST   = 3;   // payload offset of the final method-id octet

    localparam logic [7:0] FRAME_END_OCTET = 8'hCE;
    localparam logic [7:0] TYPE_METHOD     = 8'h01;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_END     = 2'd2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_METHOD  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_END   = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_type;
        logic [15:0] channel;
        logic [31:0] payload_size;
        logic [15:0] cls_id;
        logic [15:0] mth_id;
        logic [7:0]  payload_octet;
        logic        payload_last;
        logic [1:0]  end_status;
    } result_t;

endpackage

// File: design/amqp_dfr_core.sv
// Frame parsing state and per-octet decode for the AMQP deframer.
// Depends on amqp_dfr_pkg; instantiated by amqp_frame_deframer_top.
module amqp_dfr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           octet,
    input  logic                 split_method_ids,
    output logic                 res_valid,
    output amqp_dfr_pkg::result_t res
);
    import amqp_dfr_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] channel_reg, channel_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [23:0] id_shift_reg, id_shift_next;

    logic [31:0] offset;
    logic        last;
    logic        method;

    assign offset = size_reg - remaining_reg;
    assign last   = (remaining_reg[31:1] == 31'd0);
    assign method = (type_reg == TYPE_METHOD) && split_method_ids;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        type_next         = type_reg;
        channel_next      = channel_reg;
        size_next         = size_reg;
        remaining_next    = remaining_reg;
        id_shift_next     = id_shift_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (step)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    if (method && offset < 32'(ID_LAST))
                    begin
                        id_shift_next = {id_shift_reg[15:0], octet};
                    end
                    if (method && offset == 32'(ID_LAST))
                    begin
                        res.kind   = KIND_METHOD;
                        res.cls_id = id_shift_reg[23:8];
                        res.mth_id = {id_shift_reg[7:0], octet};
                    end
                    else
                    begin
                        res.kind = KIND_PAYLOAD;
                    end
                    res.payload_octet = octet;
                    res.payload_last  = last;
                    if (last)
                    begin
                        remaining_next = '0;
                        phase_next     = PH_END;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 32'd1;
                    end
                end
                PH_END:
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_END;
                    if (octet != FRAME_END_OCTET)
                    begin
                        res.end_status = ST_BAD_END;
                    end
                    else if (method && size_reg < 32'(ID_LAST + 1))
                    begin
                        res.end_status = ST_SHORT;
                    end
                    else
                    begin
                        res.end_status = ST_OK;
                    end
                    phase_next        = PH_HEADER;
                    header_count_next = '0;
                end
                default:
                begin
                    // The unused phase code is treated as the header phase.
                    phase_next = PH_HEADER;
                    if (header_count_reg == 3'd0)
                    begin
                        type_next = octet;
                    end
                    else if (header_count_reg <= 3'd2)
                    begin
                        channel_next = {channel_reg[7:0], octet};
                    end
                    else
                    begin
                        size_next = {size_reg[23:0], octet};
                    end

                    if (header_count_reg < 3'(HDR_LAST))
                    begin
                        header_count_next = header_count_reg + 3'd1;
                    end
                    else
                    begin
                        header_count_next = '0;
                        id_shift_next     = '0;
                        remaining_next    = size_next;
                        phase_next        = (size_next == 32'd0) ? PH_END : PH_PAYLOAD;
                        res_valid         = 1'b1;
                        res.kind          = KIND_HEADER;
                    end
                end
            endcase
        end

        // Identity fields last change on the octet giving the header result.
        res.frame_type   = type_next;
        res.channel      = channel_next;
        res.payload_size = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            type_reg         <= '0;
            channel_reg      <= '0;
            size_reg         <= '0;
            remaining_reg    <= '0;
            id_shift_reg     <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            type_reg         <= type_next;
            channel_reg      <= channel_next;
            size_reg         <= size_next;
            remaining_reg    <= remaining_next;
            id_shift_reg     <= id_shift_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> header_count_reg <= 3'(HDR_LAST))
        else $error("header count ran past the header length");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind != KIND_END |-> res.end_status == ST_OK)
        else $error("end status set on a non-end result");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PAYLOAD && last |=> phase_reg == PH_END)
        else $error("last payload octet did not move to the frame-end check");

endmodule

// File: design/amqp_frame_deframer_top.sv
// Two register stages: an accepted octet waits in the input register, and its result
// moves to the output register once that is empty or read. Throughput: one octet per
// cycle; a waiting result stalls the input once the input register is full.
// Header octets other than the seventh, produce no result.
// Reset (rst_n low, asynchronous) returns to the header phase, clears all frame
// state, empties both pipeline stages, and sets split_method_ids to 1.
module amqp_frame_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    // Slave stream: tdata[7:0] octet.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    // Master stream: tdata[7:0] frame_type, [23:8] channel, [55:24] payload_size,
    // [71:56] cls_id, [87:72] mth_id, [95:88] payload_octet,
    // [97:96] end_status, [103:98] zero.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [amqp_dfr_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // tuser[1:0] kind.
    output logic [1:0]   m_axis_tuser,
    // Configuration write: cfg_data is split_method_ids.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);
    import amqp_dfr_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_octet_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    logic        split_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    amqp_dfr_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .octet            (in_octet_reg),
        .split_method_ids (split_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            split_reg     <= 1'b1;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                split_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_octet_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.payload_last;
    assign m_axis_tdata  = {6'd0, out_reg.end_status, out_reg.payload_octet,
                            out_reg.mth_id, out_reg.cls_id,
                            out_reg.payload_size, out_reg.channel, out_reg.frame_type};

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_HEADER || m_axis_tuser == KIND_END)
        |-> !m_axis_tlast)
        else $error("last flag on a header or frame-end result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_reg.end_status != 2'd3)
        else $error("undefined end status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_reg))
        else $error("pending result lost or overwritten");

endmodule

// File: dv/tb_amqp_frame_deframer_top.sv
// Self-checking testbench for amqp_frame_deframer_top: directed frames, then random
// AMQP frames and noise under varying idle patterns, checked against a local deframer.
// Depends on amqp_dfr_pkg and amqp_frame_deframer_top.
`timescale 1ns / 100ps

module tb_amqp_frame_deframer_top;
    import amqp_dfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 145;

    typedef struct {
        logic [7:0] octet;
        bit         fixed;
        result_t    want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic [1:0]         m_axis_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    // Deframer state as the testbench sees it.
    logic        pr_split;
    logic [1:0]  pr_phase;
    logic [2:0]  pr_hcnt;
    logic [7:0]  pr_type;
    logic [15:0] pr_chan;
    logic [31:0] pr_size;
    logic [31:0] pr_remain;
    logic [23:0] pr_ids;

    result_t     frame_results[$];
    result_t     pred;
    result_t     seen;
    result_t     want;
    bit          row_fixed;
    result_t     row_want;
    row_t        dir_rows[$];

    int          src_idle_pct;
    int          snk_idle_pct;
    int          cycles;
    int          items_sent;
    int          frames_sent;
    int          results_checked;
    int          cfg_writes;
    int          mismatches;

    amqp_frame_deframer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic result_t frame_result(
        input logic [1:0] kind, input logic [7:0] ftype, input logic [15:0] chan,
        input logic [31:0] size, input logic [15:0] cls, input logic [15:0] mth,
        input logic [7:0] oct, input logic last, input logic [1:0] status);
        result_t r;
        r.kind          = kind;
        r.frame_type    = ftype;
        r.channel       = chan;
        r.payload_size  = size;
        r.cls_id        = cls;
        r.mth_id        = mth;
        r.payload_octet = oct;
        r.payload_last  = last;
        r.end_status    = status;
        return r;
    endfunction

    function automatic row_t row(input logic [7:0] oct, input bit fx, input result_t w);
        row_t r;
        r.octet = oct;
        r.fixed = fx;
        r.want  = w;
        return r;
    endfunction

    // Advances the deframer by one octet; returns 1 when the octet yields a result.
    function automatic bit deframe_octet(input logic [7:0] b, output result_t r);
        logic [31:0] offset;
        bit          last;
        bit          method_ids;
        r = '0;
        r.frame_type   = pr_type;
        r.channel      = pr_chan;
        r.payload_size = pr_size;
        if (pr_phase == PH_PAYLOAD)
        begin
            offset     = pr_size - pr_remain;
            last       = (pr_remain <= 1);
            method_ids = (pr_type == TYPE_METHOD) && pr_split;
            if (method_ids && offset < ID_LAST)
                pr_ids = {pr_ids[15:0], b};
            if (method_ids && offset == ID_LAST)
            begin
                r.kind   = KIND_METHOD;
                r.cls_id = pr_ids[23:8];
                r.mth_id = {pr_ids[7:0], b};
            end
            else
                r.kind = KIND_PAYLOAD;
            r.payload_octet = b;
            r.payload_last  = last;
            pr_remain       = pr_remain - 32'd1;
            if (last)
            begin
                pr_remain = '0;
                pr_phase  = PH_END;
            end
            return 1'b1;
        end
        if (pr_phase == PH_END)
        begin
            r.kind = KIND_END;
            if (b != FRAME_END_OCTET)
                r.end_status = ST_BAD_END;
            else if (pr_type == TYPE_METHOD && pr_split && pr_size <= ID_LAST)
                r.end_status = ST_SHORT;
            else
                r.end_status = ST_OK;
            pr_phase = PH_HEADER;
            pr_hcnt  = '0;
            return 1'b1;
        end
        // The spare phase code falls through to header handling.
        pr_phase = PH_HEADER;
        if (pr_hcnt == 0)
            pr_type = b;
        else if (pr_hcnt <= 2)
            pr_chan = {pr_chan[7:0], b};
        else
            pr_size = {pr_size[23:0], b};
        if (pr_hcnt < HDR_LAST)
        begin
            pr_hcnt = pr_hcnt + 3'd1;
            return 1'b0;
        end
        pr_hcnt   = '0;
        pr_ids    = '0;
        pr_remain = pr_size;
        pr_phase  = (pr_size == 0) ? PH_END : PH_PAYLOAD;
        r = frame_result(KIND_HEADER, pr_type, pr_chan, pr_size, 16'h0, 16'h0, 8'h0,
                         1'b0, ST_OK);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Requests are taken and results are checked on the same rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (cfg_valid && cfg_ready)
                pr_split = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (deframe_octet(s_axis_tdata, pred))
                    frame_results.push_back(row_fixed ? row_want : pred);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.kind          = m_axis_tuser;
                seen.frame_type    = m_axis_tdata[7:0];
                seen.channel       = m_axis_tdata[23:8];
                seen.payload_size  = m_axis_tdata[55:24];
                seen.cls_id        = m_axis_tdata[71:56];
                seen.mth_id        = m_axis_tdata[87:72];
                seen.payload_octet = m_axis_tdata[95:88];
                seen.end_status    = m_axis_tdata[97:96];
                seen.payload_last  = m_axis_tlast;
                if (frame_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result expected none actual %h kind %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = frame_results.pop_front();
                    results_checked++;
                    check_field("kind", 32'(want.kind), 32'(seen.kind));
                    check_field("frame_type", 32'(want.frame_type), 32'(seen.frame_type));
                    check_field("channel", 32'(want.channel), 32'(seen.channel));
                    check_field("payload_size", want.payload_size, seen.payload_size);
                    check_field("cls_id", 32'(want.cls_id), 32'(seen.cls_id));
                    check_field("mth_id", 32'(want.mth_id), 32'(seen.mth_id));
                    check_field("payload_octet", 32'(want.payload_octet),
                                32'(seen.payload_octet));
                    check_field("payload_last", 32'(want.payload_last),
                                32'(seen.payload_last));
                    check_field("end_status", 32'(want.end_status), 32'(seen.end_status));
                end
            end
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         frame_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

    // Called at a falling edge; returns at the falling edge after acceptance with
    // tvalid still high, so back-to-back requests never drop it.
    task automatic send_octet(input logic [7:0] b, input bit fx, input result_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 16)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        row_fixed     <= fx;
        row_want      <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        logic [7:0]  ftype;
        logic [15:0] chan;
        int          size;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 45)
            ftype = TYPE_METHOD;
        else if (pick < 60)
            ftype = 8'd2;
        else if (pick < 70)
            ftype = 8'd3;
        else if (pick < 80)
            ftype = 8'd8;
        else
            ftype = 8'($urandom_range(255));
        pick = $urandom_range(99);
        chan = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hFFFF : 16'($urandom);
        // Mostly short payloads so method ids and short methods come up often.
        size = ($urandom_range(99) < 6) ? $urandom_range(300, 13) : $urandom_range(12);
        send_octet(ftype, 1'b0, '0);
        send_octet(chan[15:8], 1'b0, '0);
        send_octet(chan[7:0], 1'b0, '0);
        for (int i = 3; i >= 0; i--)
            send_octet(8'(size >> (8 * i)), 1'b0, '0);
        repeat (size) send_octet(8'($urandom_range(255)), 1'b0, '0);
        send_octet(($urandom_range(99) < 85) ? FRAME_END_OCTET : 8'($urandom_range(255)),
                   1'b0, '0);
        frames_sent++;
    endtask

    // A truncated header of random octets; zero fill then sets the size to zero and
    // a random octet closes the frame, which brings the stream back into step.
    task automatic send_noise();
        int n;
        n = $urandom_range(3, 1);
        repeat (n) send_octet(8'($urandom_range(255)), 1'b0, '0);
        while (!(pr_phase == PH_HEADER && pr_hcnt == 0))
            send_octet((pr_phase == PH_END) ? 8'($urandom_range(255)) : 8'h00, 1'b0, '0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frame_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_split(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int phase_end;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        row_fixed     = 1'b0;
        row_want      = '0;
        pr_split      = 1'b1;
        pr_phase      = PH_HEADER;
        pr_hcnt       = '0;
        pr_type       = '0;
        pr_chan       = '0;
        pr_size       = '0;
        pr_remain     = '0;
        pr_ids        = '0;
        src_idle_pct  = 20;
        snk_idle_pct  = 45;
        cycles        = 0;
        items_sent    = 0;
        frames_sent   = 0;
        results_checked = 0;
        cfg_writes    = 0;
        mismatches    = 0;

        // Method frame with no payload and a bad frame end: bad end wins over short.
        dir_rows.push_back(row(8'h01, 1'b0, '0));
        repeat (5) dir_rows.push_back(row(8'h00, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b1, frame_result(KIND_HEADER, 8'h01, 16'h0000,
                               32'd0, 16'h0, 16'h0, 8'h00, 1'b0, ST_OK)));
        dir_rows.push_back(row(8'h00, 1'b1, frame_result(KIND_END, 8'h01, 16'h0000,
                               32'd0, 16'h0, 16'h0, 8'h00, 1'b0, ST_BAD_END)));
        // Same, but with a good frame end: the method payload is too short.
        dir_rows.push_back(row(8'h01, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b0, '0));
        dir_rows.push_back(row(8'h07, 1'b0, '0));
        repeat (3) dir_rows.push_back(row(8'h00, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b1, frame_result(KIND_HEADER, 8'h01, 16'h0007,
                               32'd0, 16'h0, 16'h0, 8'h00, 1'b0, ST_OK)));
        dir_rows.push_back(row(FRAME_END_OCTET, 1'b1, frame_result(KIND_END, 8'h01,
                               16'h0007, 32'd0, 16'h0, 16'h0, 8'h00, 1'b0, ST_SHORT)));
        // Four-octet method payload: the fourth octet carries the ids and the last flag.
        dir_rows.push_back(row(8'h01, 1'b0, '0));
        dir_rows.push_back(row(8'hFF, 1'b0, '0));
        dir_rows.push_back(row(8'hFF, 1'b0, '0));
        repeat (3) dir_rows.push_back(row(8'h00, 1'b0, '0));
        dir_rows.push_back(row(8'h04, 1'b1, frame_result(KIND_HEADER, 8'h01, 16'hFFFF,
                               32'd4, 16'h0, 16'h0, 8'h00, 1'b0, ST_OK)));
        dir_rows.push_back(row(8'h00, 1'b0, '0));
        dir_rows.push_back(row(8'h0A, 1'b0, '0));
        dir_rows.push_back(row(8'h00, 1'b0, '0));
        dir_rows.push_back(row(8'hFF, 1'b1, frame_result(KIND_METHOD, 8'h01, 16'hFFFF,
                               32'd4, 16'h000A, 16'h00FF, 8'hFF, 1'b1, ST_OK)));
        dir_rows.push_back(row(FRAME_END_OCTET, 1'b1, frame_result(KIND_END, 8'h01,
                               16'hFFFF, 32'd4, 16'h0, 16'h0, 8'h00, 1'b0, ST_OK)));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_octet(dir_rows[i].octet, dir_rows[i].fixed, dir_rows[i].want);
        frames_sent += 3;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    src_idle_pct = 20;
                    snk_idle_pct = 45;
                end
                1:
                begin
                    src_idle_pct = 45;
                    snk_idle_pct = 20;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            // The block is idle here, so the register can be rewritten safely.
            drain();
            write_split((ph < 4) ? ph[0] : 1'($urandom_range(1)));
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 12)
                    send_noise();
                else
                    send_frame();
            end
        end
        drain();

        $display("Sent %0d octets in about %0d frames plus noise, %0d config writes.",
                 items_sent, frames_sent, cfg_writes);
        $display("Checked %0d results with %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
